/* rtl/sliding_window_maximum_assert.svh */
// Assertion macros shared by the sliding window maximum RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swm_pkg.sv */
// Package for the sliding window maximum block: sizes, types, FSM states,
// controller/datapath command and status structs, index helpers. No dependencies.
package swm_pkg;

  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned SZ_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 32;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SZ_W-1:0]          size_t;

  typedef struct packed {
    sample_t value;
    pos_t    pos;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD_CHK,
    ST_HEAD_WAIT,
    ST_TAIL_CHK,
    ST_TAIL_WAIT
  } swm_state_e;

  typedef struct packed {
    logic load;
    logic drop_head;
    logic pop_tail;
    logic push;
  } swm_cmd_t;

  typedef struct packed {
    logic head_expired;
    logic tail_smaller;
    logic push_ok;
  } swm_stat_t;

  // Wrap a sum below 2*WINDOW_MAX back into the ring.
  function automatic idx_t idx_wrap(input logic [CNT_W:0] s);
    if (s >= (CNT_W+1)'(WINDOW_MAX)) begin
      return IDX_W'(s - (CNT_W+1)'(WINDOW_MAX));
    end
    return IDX_W'(s);
  endfunction

  // Clamp the programmed window into 1..WINDOW_MAX.
  function automatic size_t eff_window(input logic [CFG_W-1:0] w);
    size_t ext;
    ext = SZ_W'(w);
    if (w == '0) begin
      return SZ_W'(1);
    end
    if (ext > SZ_W'(WINDOW_MAX)) begin
      return SZ_W'(WINDOW_MAX);
    end
    return ext;
  endfunction

endpackage

/* rtl/swm_ctrl.sv */
// Controller FSM for the sliding window maximum block.
// Depends on swm_pkg and sliding_window_maximum_assert.svh.
`include "sliding_window_maximum_assert.svh"

module swm_ctrl import swm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  swm_stat_t stat_i,
  output swm_cmd_t  cmd_o
);

  swm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_HEAD_CHK;
        end
      end
      ST_HEAD_CHK: begin
        priority if (stat_i.head_expired) begin
          state_d = ST_HEAD_WAIT;
        end else if (stat_i.tail_smaller) begin
          state_d = ST_TAIL_WAIT;
        end else if (stat_i.push_ok) begin
          state_d = ST_IDLE;
        end
      end
      ST_HEAD_WAIT: state_d = ST_HEAD_CHK;
      ST_TAIL_CHK: begin
        priority if (stat_i.tail_smaller) begin
          state_d = ST_TAIL_WAIT;
        end else if (stat_i.push_ok) begin
          state_d = ST_IDLE;
        end
      end
      ST_TAIL_WAIT: state_d = ST_TAIL_CHK;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_HEAD_CHK: begin
        priority if (stat_i.head_expired) begin
          cmd_o.drop_head = 1'b1;
        end else if (stat_i.tail_smaller) begin
          cmd_o.pop_tail = 1'b1;
        end else begin
          cmd_o.push = stat_i.push_ok;
        end
      end
      ST_TAIL_CHK: begin
        priority if (stat_i.tail_smaller) begin
          cmd_o.pop_tail = 1'b1;
        end else begin
          cmd_o.push = stat_i.push_ok;
        end
      end
      ST_HEAD_WAIT, ST_TAIL_WAIT: begin
        cmd_o = '0;
      end
      default: cmd_o = '0;
    endcase
  end

  `SWM_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd_o), "more than one command at once")
  `SWM_ASSERT_NEXT(a_load_to_check, cmd_o.load, state_q == ST_HEAD_CHK,
                   "accepted beat did not reach head check")
  `SWM_ASSERT_NEXT(a_drop_waits, cmd_o.drop_head, state_q == ST_HEAD_WAIT && !in_ready_o,
                   "head drop not followed by read wait")

endmodule

/* rtl/swm_dp.sv */
// Datapath for the sliding window maximum block: queue ring memory, pointers,
// window register and output register. Depends on swm_pkg and the assert header.
`include "sliding_window_maximum_assert.svh"

module swm_dp import swm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swm_cmd_t         cmd_i,
  output swm_stat_t        stat_o,
  input  sample_t          sample_i,
  input  logic             start_req_i,
  input  logic             cfg_valid_i,
  input  logic [CFG_W-1:0] window_size_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sample_t          window_max_o
);

  entry_t           mem [WINDOW_MAX];
  entry_t           rd_head_q, rd_tail_q;
  sample_t          x_q, max_q;
  pos_t             pos_q;
  idx_t             head_q;
  cnt_t             count_q, seq_q, seq_next;
  logic [CFG_W-1:0] window_size_q;
  logic             out_valid_q;
  size_t            k;
  idx_t             tail_idx, push_idx;
  pos_t             head_age;
  logic             result_due, out_free, cnt_zero;

  assign k        = eff_window(window_size_q);
  assign cnt_zero = (count_q == '0);
  assign tail_idx = cnt_zero ? head_q
                  : idx_wrap((CNT_W+1)'(head_q) + (CNT_W+1)'(count_q - 1'b1));
  assign push_idx = idx_wrap((CNT_W+1)'(head_q) + (CNT_W+1)'(count_q));
  assign head_age = pos_q - rd_head_q.pos;
  assign seq_next = (seq_q < CNT_W'(WINDOW_MAX)) ? seq_q + 1'b1 : seq_q;
  assign result_due = (SZ_W'(seq_next) >= k);
  assign out_free   = !out_valid_q || out_ready_i;

  assign stat_o.head_expired = !cnt_zero && (head_age >= POS_W'(k));
  assign stat_o.tail_smaller = !cnt_zero && (rd_tail_q.value < x_q);
  assign stat_o.push_ok      = out_free || !result_due;

  // Ring memory: two registered read ports, one write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && count_q < CNT_W'(WINDOW_MAX)) begin
      mem[push_idx] <= '{value: x_q, pos: pos_q};
    end
    rd_head_q <= mem[head_q];
    rd_tail_q <= mem[tail_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.push && result_due) begin
      max_q <= cnt_zero ? x_q : rd_head_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= CFG_W'(1);
      head_q        <= '0;
      count_q       <= '0;
      pos_q         <= '0;
      seq_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_size_q <= window_size_i;
      end
      // Start of a new sequence: empty the queue, restart positions.
      if (cmd_i.load && start_req_i) begin
        head_q  <= '0;
        count_q <= '0;
        pos_q   <= '0;
        seq_q   <= '0;
      end
      if (cmd_i.drop_head) begin
        head_q  <= idx_wrap((CNT_W+1)'(head_q) + (CNT_W+1)'(1));
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.pop_tail) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.push) begin
        if (count_q < CNT_W'(WINDOW_MAX)) begin
          count_q <= count_q + 1'b1;
        end
        pos_q <= pos_q + 1'b1;
        seq_q <= seq_next;
      end
      if (cmd_i.push && result_due) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = max_q;

  `SWM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(WINDOW_MAX), "queue count overflow")
  `SWM_ASSERT_NOW(a_no_overwrite, cmd_i.push && result_due, out_free,
                  "result would overwrite a held beat")
  `SWM_ASSERT_NOW(a_remove_nonempty, cmd_i.drop_head || cmd_i.pop_tail, !cnt_zero,
                  "entry removed from an empty queue")

endmodule

/* rtl/sliding_window_maximum.sv */
// Sliding window maximum: running maximum over the last window_size samples.
// Channels: input beats (sample_i, start_req_i) on in_valid_i/in_ready_o,
// result beats (window_max_o) on out_valid_o/out_ready_i, and a config beat
// carrying window_size_i on cfg_valid_i/cfg_ready_o (always ready; write it
// only while the block is idle). A size of zero acts as one, sizes above 64
// act as 64.
// A beat with start_req_i set opens a new sequence and empties the queue.
// Each sample yields one result once window_size samples of the sequence
// have arrived; earlier samples yield none.
// Timing: a sample is accepted, then goes through head/tail check and push,
// with a read wait after every expired head entry dropped and every smaller
// tail entry popped; each entry leaves at most once. The registered reads
// of the queue ring memory, one port per side, set the wait after each
// removal. The result is valid the cycle after the final push.
// Reset: window size 1, queue empty, position 0; ring contents are not
// cleared. If the receiver stalls, the result is held in the output
// register and the next sample is still accepted and worked on; it waits
// at its push only if it must produce a result while the old one is held.
// Depends on swm_pkg, swm_ctrl and swm_dp.

module sliding_window_maximum import swm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sample_t          sample_i,
  input  logic             start_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sample_t          window_max_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] window_size_i
);

  swm_cmd_t  cmd;
  swm_stat_t stat;

  // Config writes land in a single register; never stall them.
  assign cfg_ready_o = 1'b1;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  swm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sample_i      (sample_i),
    .start_req_i   (start_req_i),
    .cfg_valid_i   (cfg_valid_i),
    .window_size_i (window_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .window_max_o  (window_max_o)
  );

endmodule

/* tb/sliding_window_maximum_checker.sv */
`timescale 1ns / 100ps
// Result checker for sliding_window_maximum: watches the input, config and result
// channels, predicts each window maximum and compares it with each result beat.
// Depends on swm_pkg for the sample, position and config types.
module sliding_window_maximum_checker import swm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  sample_t          sample_i,
  input  logic             start_req_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  sample_t          window_max_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] window_size_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o
);

  // Predicted state: the monotonic run of candidates, held as a ring.
  logic [CFG_W-1:0] win_cfg;
  sample_t          run_val [WINDOW_MAX];
  pos_t             run_pos [WINDOW_MAX];
  int unsigned      run_head;
  int unsigned      run_count;
  int unsigned      seq_len;
  pos_t             next_pos;
  sample_t          max_q [$];
  sample_t          want;

  function automatic int unsigned window_len(input logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return int'(w);
  endfunction

  task automatic track_sample(input sample_t x, input logic seq_start);
    int unsigned k;
    pos_t        p;
    k = window_len(win_cfg);
    if (seq_start) begin
      run_head  = 0;
      run_count = 0;
      next_pos  = '0;
      seq_len   = 0;
    end
    p = next_pos;
    // Drop candidates that have slid out of the window.
    while (run_count > 0 && pos_t'(p - run_pos[run_head]) >= k) begin
      run_head = (run_head + 1) % WINDOW_MAX;
      run_count--;
    end
    // Pop strictly smaller candidates off the tail; equal ones stay.
    while (run_count > 0 && run_val[(run_head + run_count - 1) % WINDOW_MAX] < x) begin
      run_count--;
    end
    if (run_count < WINDOW_MAX) begin
      run_val[(run_head + run_count) % WINDOW_MAX] = x;
      run_pos[(run_head + run_count) % WINDOW_MAX] = p;
      run_count++;
    end
    next_pos = p + 1;
    if (seq_len < WINDOW_MAX) seq_len++;
    if (seq_len >= k) max_q.insert(max_q.size(), run_val[run_head]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg      = CFG_W'(1);
      run_head     = 0;
      run_count    = 0;
      seq_len      = 0;
      next_pos     = '0;
      max_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (max_q.size() == 0) begin
          $display("%0t: unexpected window_max beat: expected none, actual %0d",
                   $time, window_max_i);
          mismatches_o++;
        end else begin
          want = max_q[0];
          max_q.delete(0);
          if (window_max_i !== want) begin
            $display("%0t: window_max mismatch: expected %0d, actual %0d",
                     $time, want, window_max_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) win_cfg = window_size_i;
      if (in_valid_i && in_ready_i) track_sample(sample_i, start_req_i);
      pending_o = max_q.size();
    end
  end

endmodule

/* tb/tb_sliding_window_maximum.sv */
`timescale 1ns / 100ps
// Testbench top for sliding_window_maximum: drives samples, window size writes
// and result backpressure; sliding_window_maximum_checker does the prediction.
// Depends on swm_pkg, sliding_window_maximum and sliding_window_maximum_checker.
module tb_sliding_window_maximum;
  import swm_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned PHASE_ITEMS   = 150;
  // Worst sample: accept, check, then a read wait for each of up to 64
  // removals; round up well past that before touching the window size.
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PLAN_LEN      = 12;
  localparam longint      TIMEOUT_NS    = 5_000_000;

  // Shapes of the sample content within one sequence.
  typedef enum int unsigned {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_EXTREME
  } shape_e;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  sample_t          sample;
  logic             start_req;
  logic             out_valid;
  logic             out_ready;
  sample_t          window_max;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] window_size;
  int unsigned      mismatches;
  int unsigned      pending;

  // calm turns off idling on both sides; hold_req asks the receiver for one
  // long hold-off while the sender keeps going.
  bit calm;
  bit hold_req;

  sliding_window_maximum i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (sample),
    .start_req_i   (start_req),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .window_max_o  (window_max),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .window_size_i (window_size)
  );

  sliding_window_maximum_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_i      (sample),
    .start_req_i   (start_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .window_max_i  (window_max),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .window_size_i (window_size),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("** sliding_window_maximum: FAILED **");
    $finish;
  end

  // Result side: take beats with about one idle cycle in ten, none while
  // calm, and one long hold-off on request so the block backs up into its
  // input channel.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // Offer one sample beat, maybe after a short idle gap, and hold it until
  // the block takes it. Returns in the time step of the accepting edge.
  task automatic push_sample(input sample_t v, input logic seq_start);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= v;
    start_req <= seq_start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering, wait for every predicted result, then let any sample that
  // yields no result finish its removals.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window size; only called with the block idle.
  task automatic write_window(input logic [CFG_W-1:0] w);
    cfg_valid   <= 1'b1;
    window_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t pick_value(input shape_e shape, input sample_t base,
                                         input sample_t stride, input int unsigned i);
    case (shape)
      SHAPE_RANDOM:  return sample_t'($urandom);
      // Few distinct values, so equal samples meet in the run often.
      SHAPE_NARROW:  return sample_t'($urandom_range(0, 8)) - sample_t'(4);
      // Falling ramps fill the run up to the full window.
      SHAPE_FALLING: return base - stride * sample_t'(i);
      // Rising ramps pop the whole run on each sample.
      SHAPE_RISING:  return base + stride * sample_t'(i);
      default: begin
        case ($urandom_range(0, 4))
          0:       return sample_t'(32'h7FFF_FFFF);
          1:       return sample_t'(32'h8000_0000);
          2:       return sample_t'(0);
          3:       return sample_t'(-1);
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned size_plan [PLAN_LEN] = '{1, 64, 2, 127, 5, 0, 16, 100, 33, 63, 3, 8};
    int unsigned random_items;
    int unsigned phase_items;
    int unsigned phase;
    int unsigned sz;
    int unsigned k;
    int unsigned len;
    shape_e      shape;
    sample_t     base;
    sample_t     stride;
    logic        seq_start;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    sample      <= '0;
    start_req   <= 1'b0;
    cfg_valid   <= 1'b0;
    window_size <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset window of one, no start beat at all, field extremes.
    push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    push_sample(sample_t'(32'h8000_0000), 1'b0);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(-1), 1'b0);

    // Size zero acts as one.
    settle();
    write_window(CFG_W'(0));
    push_sample(sample_t'(5), 1'b1);
    push_sample(sample_t'(-5), 1'b0);

    // Window of three: head expiry on a falling run, equal values kept,
    // a larger sample clearing the tail, and a restart mid-sequence.
    settle();
    write_window(CFG_W'(3));
    push_sample(sample_t'(10), 1'b1);
    push_sample(sample_t'(9), 1'b0);
    push_sample(sample_t'(8), 1'b0);
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(20), 1'b0);
    push_sample(sample_t'(32'h8000_0000), 1'b0);
    push_sample(sample_t'(32'h8000_0000), 1'b0);
    push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    push_sample(sample_t'(1), 1'b1);
    push_sample(sample_t'(2), 1'b0);
    push_sample(sample_t'(3), 1'b0);

    // Size above the limit saturates to 64: two samples give nothing.
    settle();
    write_window(CFG_W'(127));
    push_sample(sample_t'(-3), 1'b1);
    push_sample(sample_t'(4), 1'b0);

    // Shrink the window mid-sequence: results resume at once and the
    // now-expired head goes.
    settle();
    write_window(CFG_W'(2));
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(0), 1'b0);

    // Random phases: one window size each, mostly complete sequences with
    // random content, some cut short, a few stray restarts.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      if (phase < PLAN_LEN) begin
        sz = size_plan[phase];
      end else if ($urandom_range(1) == 1) begin
        sz = $urandom_range(1, 8);
      end else begin
        sz = $urandom_range(0, 127);
      end
      write_window(CFG_W'(sz));
      k = (sz == 0) ? 1 : ((sz > WINDOW_MAX) ? WINDOW_MAX : sz);
      calm = (phase == 1);
      if (phase == 2) hold_req = 1'b1;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        shape  = shape_e'($urandom_range(0, 4));
        base   = sample_t'($urandom);
        stride = sample_t'($urandom_range(1, 1000));
        if ($urandom_range(99) < 85) begin
          len = k + $urandom_range(0, 2 * k + 8);
        end else begin
          len = $urandom_range(1, k);
        end
        for (int unsigned i = 0; i < len; i++) begin
          // Sometimes carry the old sequence across the size change.
          if (i == 0) begin
            seq_start = !(phase_items == 0 && $urandom_range(99) < 30);
          end else begin
            seq_start = ($urandom_range(99) < 2);
          end
          push_sample(pick_value(shape, base, stride, i), seq_start);
        end
        phase_items += len;
      end
      random_items += phase_items;
      phase++;
    end

    calm = 1'b0;
    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("** sliding_window_maximum: PASSED **");
    end else begin
      $display("** sliding_window_maximum: FAILED **");
    end
    $finish;
  end

endmodule
